>>> hdl/tcw_pkg.sv
// Shared types and constants for the text console character writer.
package tcw_pkg;

	// Item modes carried in s_axis_tuser
	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_SET   = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	// Control characters handled by put, and the space used for blank cells
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	// Cell loaded by the power-up clearing pass: grey on black blank
	localparam logic [15:0] CELL_RESET = 16'h0720;

	// Result word, first field in the highest bits
	typedef struct packed {
		logic [15:0] cell_value;
		logic        scrolled;
		logic [10:0] cursor_pos;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
	} res_t;

	// Blank cell in a given attribute
	function automatic logic [15:0] blank_cell(logic [7:0] color);
		return {color, CH_SPACE};
	endfunction

endpackage

>>> hdl/text_console_char_writer_core.sv
// Top level of the text console character writer: sequencer, cursor and screen memory.
//
// Usage:
//   Items enter on the s_axis channel: s_axis_tuser carries the mode (put
//   character, clear screen, set cursor, read cell), s_axis_tdata the
//   character, attribute, column and row. Each item returns exactly one result
//   word on m_axis with the cursor, its linear position, the scroll flag and
//   the cell read.
//   The screen lives in one ROWS*COLUMNS x 16 RAM with registered read data.
//   Scrolling moves a top-row pointer and blanks one row instead of copying.
//   Steps per item: set cursor loads the cursor, then the result word; put
//   character updates cell and cursor in S_PUT, read cell reads the RAM in
//   S_READ, each before its result word; a put character that scrolls then
//   blanks one row in S_SWEEP, one cell written per cycle; clear screen
//   sweeps every cell in that manner. One item is in work at a time.
//   After reset the block runs a clearing pass over all ROWS*COLUMNS cells
//   that loads every cell with 0x0720; s_axis_tready stays low until it ends.
//   A result waits in the output register while m_axis_tready is low; the
//   engine finishes its next item and holds until the register frees up.
module text_console_char_writer_core
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // char_code[7:0], color[15:8], col[22:16], row[27:23]
	input  logic [1:0]  s_axis_tuser,  // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // cursor_col[6:0], cursor_row[11:7], cursor_pos[22:12],
	                                   // scrolled[23], cell_value[39:24]
);

	localparam int DEPTH = ROWS * COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int CXW   = $clog2(COLUMNS + 8);
	localparam int RXW   = RW + 1;

	// Sequencer states
	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_PUT   = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;
	logic [RW-1:0] top_q;
	logic [AW-1:0] top_base_q;
	logic [AW-1:0] sweep_q;
	logic [AW-1:0] end_q;
	logic [15:0]   fill_q;
	logic [1:0]    mode_q;
	logic [7:0]    ch_q;
	logic [7:0]    color_q;
	logic [CW-1:0] arg_col_q;
	logic [RW-1:0] arg_row_q;
	logic          scr_q;

	logic [1:0]    in_mode;
	logic [7:0]    in_char;
	logic [7:0]    in_color;
	logic [6:0]    in_col;
	logic [4:0]    in_row;
	logic [CW-1:0] clamp_col;
	logic [RW-1:0] clamp_row;
	logic          accept;

	logic [CXW-1:0] col_x;
	logic [RXW-1:0] row_x;
	logic           put_we;
	logic [CW-1:0]  put_wcol;
	logic [15:0]    put_wdata;
	logic           put_scroll;
	logic [CW-1:0]  put_col;
	logic [RW-1:0]  put_row;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	logic [AW-1:0] pos_full;
	logic          push;
	logic          can_push;
	res_t          res;
	res_t          res_out;

	// Physical address of a logical cell under the scroll pointer
	function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c,
			logic [RW-1:0] top);
		logic [RXW-1:0] pr;
		pr = RXW'(r) + RXW'(top);
		if (pr >= RXW'(ROWS)) begin
			pr = pr - RXW'(ROWS);
		end
		return AW'(AW'(pr) * AW'(COLUMNS)) + AW'(c);
	endfunction

	// Unpack the input word
	assign in_mode  = s_axis_tuser;
	assign in_char  = s_axis_tdata[7:0];
	assign in_color = s_axis_tdata[15:8];
	assign in_col   = s_axis_tdata[22:16];
	assign in_row   = s_axis_tdata[27:23];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Clamp column and row to the grid
	assign clamp_col = (int'(in_col) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(in_col);
	assign clamp_row = (int'(in_row) >= ROWS) ? RW'(ROWS - 1) : RW'(in_row);

	// Put character: cell write and cursor update
	always_comb begin
		col_x     = CXW'(cur_col_q);
		row_x     = RXW'(cur_row_q);
		put_we    = 1'b0;
		put_wcol  = cur_col_q;
		put_wdata = {color_q, ch_q};
		case (ch_q)
			CH_NEWLINE: begin
				col_x = '0;
				row_x = row_x + RXW'(1);
			end
			CH_RETURN: begin
				col_x = '0;
			end
			CH_TAB: begin
				col_x = (col_x + CXW'(8)) & ~CXW'(7);
			end
			CH_BACKSPACE: begin
				if (cur_col_q != '0) begin
					col_x     = col_x - CXW'(1);
					put_we    = 1'b1;
					put_wcol  = cur_col_q - CW'(1);
					put_wdata = blank_cell(color_q);
				end
			end
			default: begin
				put_we = 1'b1;
				col_x  = col_x + CXW'(1);
			end
		endcase
		if (col_x >= CXW'(COLUMNS)) begin
			col_x = '0;
			row_x = row_x + RXW'(1);
		end
		put_scroll = (row_x >= RXW'(ROWS));
		put_col    = CW'(col_x);
		put_row    = put_scroll ? RW'(ROWS - 1) : RW'(row_x);
	end

	// Memory port selection
	assign ram_we    = (state_q == S_PUT) ? put_we :
	                   ((state_q == S_SWEEP) || (state_q == S_INIT));
	assign ram_waddr = (state_q == S_PUT) ? cell_addr(cur_row_q, put_wcol, top_q) : sweep_q;
	assign ram_wdata = (state_q == S_PUT) ? put_wdata : fill_q;
	assign ram_re    = (state_q == S_READ);
	assign ram_raddr = cell_addr(arg_row_q, arg_col_q, top_q);

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer, cursor and scroll pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			top_q      <= '0;
			top_base_q <= '0;
			sweep_q    <= '0;
			end_q      <= AW'(DEPTH - 1);
			fill_q     <= CELL_RESET;
			scr_q      <= 1'b0;
			mode_q     <= MODE_PUT;
		end else begin
			case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == end_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						mode_q <= in_mode;
						scr_q  <= 1'b0;
						case (in_mode)
							MODE_PUT: begin
								state_q <= S_PUT;
							end
							MODE_CLEAR: begin
								cur_col_q  <= '0;
								cur_row_q  <= '0;
								top_q      <= '0;
								top_base_q <= '0;
								sweep_q    <= '0;
								end_q      <= AW'(DEPTH - 1);
								fill_q     <= blank_cell(in_color);
								state_q    <= S_SWEEP;
							end
							MODE_SET: begin
								cur_col_q <= clamp_col;
								cur_row_q <= clamp_row;
								state_q   <= S_RESP;
							end
							default: begin
								state_q <= S_READ;
							end
						endcase
					end
				end
				S_PUT: begin
					cur_col_q <= put_col;
					cur_row_q <= put_row;
					if (put_scroll) begin
						// Blank the old top row; it becomes the bottom row
						scr_q   <= 1'b1;
						sweep_q <= top_base_q;
						end_q   <= top_base_q + AW'(COLUMNS - 1);
						fill_q  <= blank_cell(color_q);
						if (top_q == RW'(ROWS - 1)) begin
							top_q      <= '0;
							top_base_q <= '0;
						end else begin
							top_q      <= top_q + RW'(1);
							top_base_q <= top_base_q + AW'(COLUMNS);
						end
						state_q <= S_SWEEP;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == end_q) begin
						state_q <= S_RESP;
					end
				end
				S_READ: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (can_push) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item arguments
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q      <= in_char;
			color_q   <= in_color;
			arg_col_q <= clamp_col;
			arg_row_q <= clamp_row;
		end
	end

	// Assemble the result word
	assign pos_full = AW'(AW'(cur_row_q) * AW'(COLUMNS)) + AW'(cur_col_q);

	always_comb begin
		res.cursor_col = 7'(cur_col_q);
		res.cursor_row = 5'(cur_row_q);
		res.cursor_pos = 11'(pos_full);
		res.scrolled   = scr_q;
		res.cell_value = (mode_q == MODE_READ) ? ram_rdata : 16'h0000;
	end

	assign push = (state_q == S_RESP);

	tcw_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.word_in   (res),
		.can_push  (can_push),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.word_out  (res_out)
	);

	assign m_axis_tdata = res_out;

	// Cursor stays on the grid
	a_cursor_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(cur_col_q) < COLUMNS) && (int'(cur_row_q) < ROWS))
		else $error("cursor left the grid");

	// Incremental row base tracks the scroll pointer
	a_top_base: assert property (@(posedge clk) disable iff (!arst_n)
		top_base_q == AW'(AW'(top_q) * AW'(COLUMNS)))
		else $error("scroll base out of step with top row");

	// An accepted item always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("item accepted without being worked");

	// Sweeps never run past their end address
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP || state_q == S_INIT) |-> sweep_q <= end_q)
		else $error("sweep ran past its end");

	// Scroll flag only set by a put character item
	a_scroll_mode: assert property (@(posedge clk) disable iff (!arst_n)
		push && scr_q |-> mode_q == MODE_PUT)
		else $error("scroll reported for a non-put item");

endmodule

>>> hdl/tcw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/tcw_out_stage.sv
// Output register for result words, decoupling the engine from the receiver.
module tcw_out_stage
	import tcw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t word_in,
	output logic can_push,
	output logic out_valid,
	input  logic out_ready,
	output res_t word_out
);

	logic valid_q;
	res_t word_q;

	// Slot is free when empty or being drained this cycle
	assign can_push  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign word_out  = word_q;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push && can_push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load the word
	always_ff @(posedge clk) begin
		if (push && can_push) begin
			word_q <= word_in;
		end
	end

	// A word offered and refused stays in the register
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(word_q))
		else $error("result word dropped or changed while stalled");

endmodule
